// ===== rtl/vhr_pkg.sv =====
// vhr_pkg: shared types, widths and saturation helpers for the motion integrator
// no dependencies; imported by vhr_mul, vhr_div and velocity_heading_ramp_integrator
`default_nettype none

package vhr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CMD_W         = 2;
  localparam int TIME_W        = 24;
  localparam int VEL_W         = 32;
  localparam int POS_W         = 48;
  localparam int PROD_W        = VEL_W + TIME_W + 1;
  localparam int DEN_W         = 34;

  typedef logic        [TIME_W-1:0] time_t;
  typedef logic signed [VEL_W-1:0]  vel_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [DEN_W-1:0]  den_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_RAMP = 2'd1,
    CMD_TURN = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    time_t             time_step;
    vel_t              goal_vel_x;
    vel_t              goal_vel_y;
    vel_t              goal_vel_z;
    vel_t              goal_heading;
  } in_item_t;

  typedef struct packed {
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
    vel_t heading;
    vel_t vel_x;
    vel_t vel_y;
    vel_t vel_z;
    logic ramping;
    logic turning;
  } out_item_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic vel_t sat32(input logic signed [63:0] x);
    vel_t r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'h8000_0000;
    else r = x[VEL_W-1:0];
    return r;
  endfunction

  function automatic pos_t sat48(input logic signed [63:0] x);
    pos_t r;
    if (x > 64'sh0000_7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
    else if (x < -64'sh0000_8000_0000_0000) r = 48'h8000_0000_0000;
    else r = x[POS_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vhr_mul.sv =====
// vhr_mul: bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle
// depends on vhr_pkg
`default_nettype none

module vhr_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  vhr_pkg::vel_t      mcand_i,
  input  vhr_pkg::time_t     mplier_i,
  output vhr_pkg::unit_stat_t stat_o,
  output vhr_pkg::prod_t     prod_o
);
  import vhr_pkg::*;

  localparam int CntW = $clog2(TIME_W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  prod_t           acc_q, acc_d;
  vel_t            mc_q, mc_d;
  time_t           mp_q, mp_d;
  prod_t           addend;

  // msb-first shift and add
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    addend = mp_q[TIME_W-1] ? prod_t'(mc_q) : '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(TIME_W);
      acc_d  = '0;
      mc_d   = mcand_i;
      mp_d   = mplier_i;
    end else if (busy_q) begin
      acc_d = (acc_q <<< 1) + addend;
      mp_d  = {mp_q[TIME_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

`default_nettype wire

// ===== rtl/vhr_div.sv =====
// vhr_div: restoring unsigned divider, one quotient bit per cycle
// depends on vhr_pkg
`default_nettype none

module vhr_div #(
  parameter int NumW = 49
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumW-1:0]     num_i,
  input  vhr_pkg::den_t       den_i,
  output vhr_pkg::unit_stat_t stat_o,
  output logic [NumW-1:0]     quo_o,
  output vhr_pkg::den_t       rem_o
);
  import vhr_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  den_t            rem_q, rem_d;
  den_t            den_q, den_d;
  logic [DEN_W:0]  shifted;
  logic [DEN_W:0]  trial;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    shifted = {rem_q, quo_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[DEN_W]) begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DEN_W-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

// ===== rtl/velocity_heading_ramp_integrator.sv =====
// velocity_heading_ramp_integrator: top level, command sequencer and motion state
// depends on vhr_pkg, vhr_mul, vhr_div
//
//   port group   direction  payload               handshake
//   in           input      vhr_pkg::in_item_t    in_valid_i / in_ready_o
//   out          output     vhr_pkg::out_item_t   out_valid_o / out_ready_i
//
// one item at a time; every product goes through the serial multiplier,
// every quotient through the serial divider
// tick: 3 products without a ramp, up to 12 with one, plus 1 for a turn
// ramp start: 3 quotients, none for zero duration; turn start: up to 2 quotients
// unused command: no arithmetic; reset clears all motion state to zero; no clearing pass
// a result waiting on out_ready_i does not block the next item; a second result holds it
`default_nettype none

module velocity_heading_ramp_integrator #(
  parameter int FRAC_BITS = vhr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vhr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vhr_pkg::out_item_t out_item_o
);
  import vhr_pkg::*;

  localparam int NumW = 33 + FRAC_BITS;
  localparam logic signed [35:0] HalfTurn = 36'sd180 <<< FRAC_BITS;
  localparam logic signed [35:0] FullTurn = 36'sd360 <<< FRAC_BITS;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DISP   = 8'b0000_0010,
    ST_TSET   = 8'b0000_0100,
    ST_MSTART = 8'b0000_1000,
    ST_MWAIT  = 8'b0001_0000,
    ST_DSTART = 8'b0010_0000,
    ST_DWAIT  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    STEP_ACC,
    STEP_VEL,
    STEP_DV,
    STEP_TGT,
    STEP_TURN
  } step_e;

  typedef enum logic [1:0] {
    PH_WRAP_HI,
    PH_WRAP_LO,
    PH_RATE
  } phase_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  phase_e phase_q, phase_d;
  logic [1:0] axis_q, axis_d;

  // motion state
  pos_t  pos_q [3];
  pos_t  pos_d [3];
  vel_t  vel_q [3];
  vel_t  vel_d [3];
  vel_t  acc_q [3];
  vel_t  acc_d [3];
  vel_t  tgt_q [3];
  vel_t  tgt_d [3];
  time_t rtl_q, rtl_d;
  vel_t  head_q, head_d;
  vel_t  rate_q, rate_d;
  vel_t  ttarget_q, ttarget_d;
  time_t ttl_q, ttl_d;

  // latched item and per-item work registers
  cmd_e  cmd_q, cmd_d;
  time_t dt_q, dt_d;
  vel_t  goal_q [3];
  vel_t  goal_d [3];
  vel_t  ghead_q, ghead_d;
  logic  ramp_q, ramp_d;
  logic  ends_q, ends_d;
  time_t teff_q, teff_d;
  time_t rest_q, rest_d;
  vel_t  dv_q, dv_d;
  logic signed [59:0] off_q, off_d;
  logic signed [35:0] diff_q, diff_d;

  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      out_load;

  // arithmetic units
  logic       mul_start, div_start;
  unit_stat_t mul_stat, div_stat;
  vel_t       mul_mcand;
  time_t      mul_mplier;
  prod_t      mul_prod;
  logic [NumW-1:0] div_num, div_quo;
  den_t       div_den, div_rem;

  logic signed [35:0] turn_diff, div_signed, div_abs, rem_s;
  logic               div_neg;
  vel_t               quo_sat;
  logic               big_pos, big_neg;
  logic signed [59:0] off_sum;
  logic               commit;

  vhr_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .stat_o   (mul_stat),
    .prod_o   (mul_prod)
  );

  vhr_div #(.NumW(NumW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // multiplier operand select
  always_comb begin
    mul_mcand  = vel_q[axis_q];
    mul_mplier = teff_q;
    unique case (step_q)
      STEP_ACC:  mul_mcand = acc_q[axis_q];
      STEP_VEL:  mul_mcand = vel_q[axis_q];
      STEP_DV:   mul_mcand = dv_q;
      STEP_TGT: begin
        mul_mcand  = tgt_q[axis_q];
        mul_mplier = rest_q;
      end
      STEP_TURN: begin
        mul_mcand  = rate_q;
        mul_mplier = dt_q;
      end
      default: mul_mcand = vel_q[axis_q];
    endcase
  end

  // divider operand select and quotient saturation
  assign turn_diff  = 36'(ghead_q) - 36'(head_q);
  assign div_signed = (cmd_q == CMD_RAMP) ? (36'(goal_q[axis_q]) - 36'(vel_q[axis_q]))
                                          : diff_q;
  assign div_neg    = div_signed[35];
  assign div_abs    = div_neg ? -div_signed : div_signed;
  assign rem_s      = $signed({2'b00, div_rem});

  always_comb begin
    div_num = {div_abs[32:0], {FRAC_BITS{1'b0}}};
    div_den = den_t'(dt_q);
    if (cmd_q == CMD_TURN) begin
      unique case (phase_q)
        PH_WRAP_HI: begin
          div_num = NumW'($unsigned(diff_q - HalfTurn));
          div_den = den_t'(FullTurn);
        end
        PH_WRAP_LO: begin
          div_num = NumW'($unsigned(-HalfTurn - diff_q));
          div_den = den_t'(FullTurn);
        end
        default: div_num = {div_abs[32:0], {FRAC_BITS{1'b0}}};
      endcase
    end
  end

  assign big_pos = |div_quo[NumW-1:31];
  assign big_neg = (|div_quo[NumW-1:32]) || (div_quo[31] && (|div_quo[30:0]));

  always_comb begin
    if (div_neg) quo_sat = big_neg ? 32'h8000_0000 : -div_quo[31:0];
    else quo_sat = big_pos ? 32'h7FFF_FFFF : div_quo[31:0];
  end

  // command sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_d     = phase_q;
    axis_d      = axis_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    acc_d       = acc_q;
    tgt_d       = tgt_q;
    rtl_d       = rtl_q;
    head_d      = head_q;
    rate_d      = rate_q;
    ttarget_d   = ttarget_q;
    ttl_d       = ttl_q;
    cmd_d       = cmd_q;
    dt_d        = dt_q;
    goal_d      = goal_q;
    ghead_d     = ghead_q;
    ramp_d      = ramp_q;
    ends_d      = ends_q;
    teff_d      = teff_q;
    rest_d      = rest_q;
    dv_d        = dv_q;
    off_d       = off_q;
    diff_d      = diff_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    commit      = 1'b0;
    off_sum     = off_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = cmd_e'(in_item_i.cmd);
          dt_d      = in_item_i.time_step;
          goal_d[0] = in_item_i.goal_vel_x;
          goal_d[1] = in_item_i.goal_vel_y;
          goal_d[2] = in_item_i.goal_vel_z;
          ghead_d   = in_item_i.goal_heading;
          state_d   = ST_DISP;
        end
      end

      ST_DISP: begin
        axis_d = 2'd0;
        unique case (cmd_q)
          CMD_TICK: begin
            if (rtl_q != '0) begin
              ramp_d = 1'b1;
              ends_d = rtl_q <= dt_q;
              teff_d = (rtl_q <= dt_q) ? rtl_q : dt_q;
              rest_d = dt_q - teff_d;
              step_d = STEP_ACC;
            end else begin
              ramp_d = 1'b0;
              ends_d = 1'b0;
              teff_d = dt_q;
              rest_d = '0;
              step_d = STEP_VEL;
            end
            state_d = ST_MSTART;
          end
          CMD_RAMP: begin
            tgt_d = goal_q;
            if (dt_q == '0) begin
              vel_d   = goal_q;
              acc_d   = '{default: '0};
              rtl_d   = '0;
              state_d = ST_OUT;
            end else begin
              state_d = ST_DSTART;
            end
          end
          CMD_TURN: begin
            diff_d = turn_diff;
            if (turn_diff > HalfTurn) begin
              phase_d = PH_WRAP_HI;
              state_d = ST_DSTART;
            end else if (turn_diff < -HalfTurn) begin
              phase_d = PH_WRAP_LO;
              state_d = ST_DSTART;
            end else begin
              state_d = ST_TSET;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end

      // turn start once the difference is wrapped
      ST_TSET: begin
        ttarget_d = ghead_q;
        ttl_d     = dt_q;
        if (dt_q == '0) begin
          head_d  = ghead_q;
          rate_d  = '0;
          state_d = ST_OUT;
        end else begin
          phase_d = PH_RATE;
          state_d = ST_DSTART;
        end
      end

      ST_MSTART: begin
        mul_start = 1'b1;
        state_d   = ST_MWAIT;
      end

      ST_MWAIT: begin
        if (mul_stat.done) begin
          unique case (step_q)
            STEP_ACC: begin
              dv_d    = sat32(64'(mul_prod >>> FRAC_BITS));
              step_d  = STEP_VEL;
              state_d = ST_MSTART;
            end
            STEP_VEL: begin
              off_sum = 60'(mul_prod >>> FRAC_BITS);
              off_d   = off_sum;
              if (ramp_q) begin
                step_d  = STEP_DV;
                state_d = ST_MSTART;
              end else begin
                commit = 1'b1;
              end
            end
            STEP_DV: begin
              off_sum = off_q + 60'(mul_prod >>> (FRAC_BITS + 1));
              off_d   = off_sum;
              if (ends_q) begin
                step_d  = STEP_TGT;
                state_d = ST_MSTART;
              end else begin
                commit = 1'b1;
              end
            end
            STEP_TGT: begin
              off_sum = off_q + 60'(mul_prod >>> FRAC_BITS);
              off_d   = off_sum;
              commit  = 1'b1;
            end
            STEP_TURN: begin
              head_d  = sat32(64'(head_q) + 64'(mul_prod >>> FRAC_BITS));
              ttl_d   = ttl_q - dt_q;
              state_d = ST_OUT;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end

      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end

      ST_DWAIT: begin
        if (div_stat.done) begin
          if (cmd_q == CMD_RAMP) begin
            acc_d[axis_q] = quo_sat;
            if (axis_q != 2'd2) begin
              axis_d  = axis_q + 2'd1;
              state_d = ST_DSTART;
            end else begin
              rtl_d   = dt_q;
              state_d = ST_OUT;
            end
          end else begin
            unique case (phase_q)
              PH_WRAP_HI: begin
                diff_d  = (div_rem == '0) ? HalfTurn : HalfTurn + rem_s - FullTurn;
                state_d = ST_TSET;
              end
              PH_WRAP_LO: begin
                diff_d  = (div_rem == '0) ? -HalfTurn : -HalfTurn - rem_s + FullTurn;
                state_d = ST_TSET;
              end
              default: begin
                rate_d  = quo_sat;
                state_d = ST_OUT;
              end
            endcase
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load      = 1'b1;
          out_d.pos_x   = pos_q[0];
          out_d.pos_y   = pos_q[1];
          out_d.pos_z   = pos_q[2];
          out_d.heading = head_q;
          out_d.vel_x   = vel_q[0];
          out_d.vel_y   = vel_q[1];
          out_d.vel_z   = vel_q[2];
          out_d.ramping = rtl_q != '0;
          out_d.turning = ttl_q != '0;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // finish one axis of a tick
    if (commit) begin
      pos_d[axis_q] = sat48(64'(pos_q[axis_q]) + 64'(off_sum));
      if (ramp_q) begin
        if (ends_q) begin
          vel_d[axis_q] = tgt_q[axis_q];
          acc_d[axis_q] = '0;
        end else begin
          vel_d[axis_q] = sat32(64'(vel_q[axis_q]) + 64'(dv_q));
        end
      end
      if (axis_q != 2'd2) begin
        axis_d  = axis_q + 2'd1;
        step_d  = ramp_q ? STEP_ACC : STEP_VEL;
        state_d = ST_MSTART;
      end else begin
        if (ramp_q) rtl_d = ends_q ? '0 : rtl_q - dt_q;
        if (ttl_q != '0) begin
          if (ttl_q <= dt_q) begin
            ttl_d   = '0;
            rate_d  = '0;
            head_d  = ttarget_q;
            state_d = ST_OUT;
          end else begin
            step_d  = STEP_TURN;
            state_d = ST_MSTART;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
    end
  end

  // control and motion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_ACC;
      phase_q     <= PH_RATE;
      axis_q      <= 2'd0;
      pos_q       <= '{default: '0};
      vel_q       <= '{default: '0};
      acc_q       <= '{default: '0};
      tgt_q       <= '{default: '0};
      rtl_q       <= '0;
      head_q      <= '0;
      rate_q      <= '0;
      ttarget_q   <= '0;
      ttl_q       <= '0;
      cmd_q       <= CMD_NONE;
      ramp_q      <= 1'b0;
      ends_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      axis_q      <= axis_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      acc_q       <= acc_d;
      tgt_q       <= tgt_d;
      rtl_q       <= rtl_d;
      head_q      <= head_d;
      rate_q      <= rate_d;
      ttarget_q   <= ttarget_d;
      ttl_q       <= ttl_d;
      cmd_q       <= cmd_d;
      ramp_q      <= ramp_d;
      ends_q      <= ends_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item payload and scratch values
  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    goal_q  <= goal_d;
    ghead_q <= ghead_d;
    teff_q  <= teff_d;
    rest_q  <= rest_d;
    dv_q    <= dv_d;
    off_q   <= off_d;
    diff_q  <= diff_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // an accepted item keeps the sequencer busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // units are only started when free
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // reported flags follow the remaining times
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_item_o.ramping == (rtl_q != '0)) &&
                 (out_item_o.turning == (ttl_q != '0)))
    else $error("status flags disagree with remaining times");

  // acceleration only survives while a ramp is running
  a_acc_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && (acc_q[0] != '0 || acc_q[1] != '0 || acc_q[2] != '0))
      |-> rtl_q != '0)
    else $error("acceleration left without a ramp");

endmodule

`default_nettype wire
